// ===== rtl/rdc_pkg.sv =====
// Shared types, constants and helper functions for the radix digit converter.
package rdc_pkg;

    localparam int VALUE_W   = 63;
    localparam int WORK_W    = 64;
    localparam int BYTE_W    = 8;
    localparam int BYTE_CNT  = WORK_W / BYTE_W;
    localparam int BIDX_W    = $clog2(BYTE_CNT);
    localparam int RADIX_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 7;
    localparam int TDATA_IN  = 64;
    localparam int TDATA_OUT = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_A     = 7'd65;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 4'd10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic               done;
        logic [WORK_W-1:0]  quot;
        logic [DIGIT_W-1:0] rem;
    } div_res_t;

    // one output beat
    typedef struct packed {
        logic              last;
        logic [CHAR_W-1:0] chr;
    } beat_t;

    // saturate register value into 2..16
    function automatic logic [RADIX_W-1:0] eff_base(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        b = r;
        if (r < RADIX_MIN)
            b = RADIX_MIN;
        else if (r > RADIX_MAX)
            b = RADIX_MAX;
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS)
            c = ASCII_ZERO + CHAR_W'(d);
        else
            c = ASCII_A + CHAR_W'(d - DEC_DIGITS);
        return c;
    endfunction

endpackage

// ===== rtl/rdc_divider.sv =====
// Iterative divide-by-base unit, one byte of the dividend per cycle.
module rdc_divider
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [rdc_pkg::WORK_W-1:0]       dividend,
    input  logic [rdc_pkg::RADIX_W-1:0]      base,
    output rdc_pkg::div_res_t                res
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [rdc_pkg::BIDX_W-1:0]   idx_reg, idx_next;
    logic [rdc_pkg::WORK_W-1:0]   work_reg, work_next;
    logic [rdc_pkg::DIGIT_W-1:0]  rem_reg, rem_next;

    logic [rdc_pkg::BIDX_W-1:0]   top_idx;
    logic [rdc_pkg::BYTE_W-1:0]   byte_in;
    logic [rdc_pkg::BYTE_W-1:0]   byte_q;
    logic [rdc_pkg::DIGIT_W-1:0]  byte_rem;

    // highest nonzero byte of the new dividend; leading zero bytes are skipped
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < rdc_pkg::BYTE_CNT; i++)
        begin
            if (dividend[i*rdc_pkg::BYTE_W +: rdc_pkg::BYTE_W] != '0)
                top_idx = rdc_pkg::BIDX_W'(i);
        end
    end

    // eight restoring long-division steps on a 5-bit partial remainder
    always_comb
    begin
        logic [rdc_pkg::DIGIT_W:0] r;
        byte_in  = work_reg[idx_reg*rdc_pkg::BYTE_W +: rdc_pkg::BYTE_W];
        byte_q   = '0;
        r        = {1'b0, rem_reg};
        for (int j = rdc_pkg::BYTE_W - 1; j >= 0; j--)
        begin
            r = {r[rdc_pkg::DIGIT_W-1:0], byte_in[j]};
            if (r >= base)
            begin
                r         = r - base;
                byte_q[j] = 1'b1;
            end
        end
        byte_rem = r[rdc_pkg::DIGIT_W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = top_idx;
            work_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            work_next[idx_reg*rdc_pkg::BYTE_W +: rdc_pkg::BYTE_W] = byte_q;
            rem_next = byte_rem;
            if (idx_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg - rdc_pkg::BIDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign res.done = done_reg;
    assign res.quot = work_reg;
    assign res.rem  = rem_reg;

endmodule

// ===== rtl/rdc_digit_ram.sv =====
// Digit store: one write port, one read port, registered read data.
module rdc_digit_ram #(
    parameter int DEPTH = 64
)
(
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH)-1:0]          waddr,
    input  logic [rdc_pkg::DIGIT_W-1:0]       wdata,
    input  logic                              re,
    input  logic [$clog2(DEPTH)-1:0]          raddr,
    output logic [rdc_pkg::DIGIT_W-1:0]       rdata
);

    logic [rdc_pkg::DIGIT_W-1:0] mem [DEPTH];
    logic [rdc_pkg::DIGIT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rdc_out_buf.sv =====
// Two-entry output buffer that decouples the digit reads from the receiver.
module rdc_out_buf
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  rdc_pkg::beat_t                    push_beat,
    output logic [1:0]                        count,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rdc_pkg::TDATA_OUT-1:0]     m_tdata,
    output logic                              m_tlast
);

    rdc_pkg::beat_t  buf_mem [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            pop;
    rdc_pkg::beat_t  head;

    assign pop = m_tvalid && m_tready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_mem[wr_ptr_reg] <= push_beat;
    end

    assign head     = buf_mem[rd_ptr_reg];
    assign count    = cnt_reg;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {{(rdc_pkg::TDATA_OUT - rdc_pkg::CHAR_W){1'b0}}, head.chr};
    assign m_tlast  = head.last;

endmodule

// ===== rtl/radix_digit_converter_core.sv =====
// Top level: converts an unsigned integer to an ASCII digit string in a set base.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the 5-bit radix; values below
//   2 act as 2, above 16 as 16. Reset value is 10. Write only while the block idles.
//   Slave stream carries one 63-bit value per beat; master stream returns one ASCII
//   character per beat, most significant digit first, tlast on the final digit.
//   Zero converts to a single '0'. At most min(MAX_DIGITS, 63) digits come out;
//   longer results keep the least significant digits.
// Timing:
//   Each digit takes one divider pass over the bytes up to the highest nonzero byte of
//   the current quotient (1..8 bytes); the divider retires eight quotient bits a cycle.
//   Emission then reads the digit store at one digit per cycle while the output buffer
//   has room; a digit reaches m_tvalid via the read data register, then the buffer.
//   s_tready is high only between conversions; it rises once the last digit read
//   is issued, while the final beats may still wait in the output buffer.
// Reset clears the sequencer, counters and output buffer. A stalled receiver
// holds the buffer full and pauses digit reads; nothing is dropped.
module radix_digit_converter_core #(
    parameter int MAX_DIGITS = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rdc_pkg::RADIX_W-1:0]       cfg_data,      // radix
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rdc_pkg::TDATA_IN-1:0]      s_tdata,       // [62:0] value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rdc_pkg::TDATA_OUT-1:0]     m_tdata,       // [6:0] digit_char
    output logic                              m_tlast
);

    localparam int LIMIT  = (MAX_DIGITS > 63) ? 63 : MAX_DIGITS;
    localparam int CNT_W  = $clog2(LIMIT + 1);
    localparam int ADDR_W = $clog2(MAX_DIGITS);

    rdc_pkg::state_t               state_reg, state_next;
    logic [rdc_pkg::RADIX_W-1:0]   radix_reg;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          rd_pend_reg;
    logic                          rd_last_reg;

    rdc_pkg::div_res_t             div_res;
    logic                          div_start;
    logic [rdc_pkg::WORK_W-1:0]    div_in;
    logic [rdc_pkg::RADIX_W-1:0]   base;

    logic                          ram_we;
    logic                          ram_re;
    logic [CNT_W-1:0]              rd_cnt;
    logic [rdc_pkg::DIGIT_W-1:0]   ram_rdata;

    logic [1:0]                    buf_count;
    logic [1:0]                    occ;
    logic                          pop;
    logic                          can_issue;
    logic                          in_acc;
    logic                          div_fin;
    logic                          div_stop;
    rdc_pkg::beat_t                push_beat;

    assign cfg_ready = 1'b1;
    assign base      = rdc_pkg::eff_base(radix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= rdc_pkg::RADIX_RESET;
        else if (cfg_valid && cfg_ready)
            radix_reg <= cfg_data;
    end

    assign in_acc   = s_tvalid && s_tready;
    assign div_fin  = (state_reg == rdc_pkg::S_DIV) && div_res.done;
    assign div_stop = (div_res.quot == '0) || (count_reg + CNT_W'(1) == CNT_W'(LIMIT));
    assign pop      = m_tvalid && m_tready;
    // buffer entries plus the read in flight must leave room for another beat
    assign occ       = buf_count + 2'(rd_pend_reg);
    assign can_issue = (occ < 2'd2) || ((occ == 2'd2) && pop);
    assign rd_cnt    = count_reg - CNT_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rdc_pkg::S_IDLE:
            begin
                if (in_acc)
                    state_next = rdc_pkg::S_DIV;
            end
            rdc_pkg::S_DIV:
            begin
                if (div_fin && div_stop)
                    state_next = rdc_pkg::S_EMIT;
            end
            rdc_pkg::S_EMIT:
            begin
                if (can_issue && (count_reg == CNT_W'(1)))
                    state_next = rdc_pkg::S_IDLE;
            end
            default:
                state_next = rdc_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        div_in    = div_res.quot;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        unique case (state_reg)
            rdc_pkg::S_IDLE:
            begin
                s_tready  = 1'b1;
                div_start = s_tvalid;
                div_in    = {1'b0, s_tdata[rdc_pkg::VALUE_W-1:0]};
            end
            rdc_pkg::S_DIV:
            begin
                ram_we    = div_res.done;
                div_start = div_res.done && !div_stop;
            end
            rdc_pkg::S_EMIT:
            begin
                ram_re = can_issue;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_acc)
            count_next = '0;
        else if (ram_we)
            count_next = count_reg + CNT_W'(1);
        else if (ram_re)
            count_next = rd_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rdc_pkg::S_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= ram_re;
            rd_last_reg <= (count_reg == CNT_W'(1));
        end
    end

    rdc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .base     (base),
        .res      (div_res)
    );

    // writes happen only while dividing, reads only while emitting: no overlap
    rdc_digit_ram #(
        .DEPTH (MAX_DIGITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (div_res.rem),
        .re    (ram_re),
        .raddr (rd_cnt[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign push_beat.last = rd_last_reg;
    assign push_beat.chr  = rdc_pkg::digit_char(ram_rdata);

    rdc_out_buf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rd_pend_reg),
        .push_beat (push_beat),
        .count     (buf_count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rdc_pkg::S_EMIT) |-> (count_reg != '0))
        else $error("emit with empty digit count");

    a_buf_room: assert property (@(posedge clk) disable iff (!rst_n)
        (occ <= 2'd2))
        else $error("output buffer overcommitted");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == rdc_pkg::S_DIV))
        else $error("divider result outside divide phase");

    a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == rdc_pkg::S_DIV) && (count_reg == '0))
        else $error("accepted beat did not start conversion");

    a_count_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(LIMIT)))
        else $error("digit count above limit");
`endif

endmodule

// ===== tb/tb_radix_digit_converter_core.sv =====
// Self-checking testbench for radix_digit_converter_core: random and directed values over several bases.
`timescale 1ns / 100ps

class digit_scoreboard;
    typedef struct {
        logic [rdc_pkg::CHAR_W-1:0] chr;
        logic                       last;
    } digit_beat_t;

    localparam logic [rdc_pkg::CHAR_W-1:0]  CH_ZERO  = 7'd48;
    localparam logic [rdc_pkg::CHAR_W-1:0]  CH_ALPHA = 7'd65;
    localparam logic [rdc_pkg::DIGIT_W-1:0] TEN      = 4'd10;

    logic [rdc_pkg::RADIX_W-1:0] radix_reg;
    int unsigned                 digit_cap;
    digit_beat_t                 pending_digits[$];
    int unsigned                 mismatches;

    function new(int unsigned cap);
        radix_reg  = rdc_pkg::RADIX_RESET;
        digit_cap  = (cap > 63) ? 63 : ((cap < 1) ? 1 : cap);
        mismatches = 0;
    endfunction

    function void set_radix(logic [rdc_pkg::RADIX_W-1:0] r);
        radix_reg = r;
    endfunction

    // expand one accepted value into its digit beats, most significant first
    function void note_value(logic [rdc_pkg::VALUE_W-1:0] v);
        logic [63:0]                  quot;
        logic [63:0]                  base;
        logic [rdc_pkg::DIGIT_W-1:0]  rems[$];
        logic [rdc_pkg::DIGIT_W-1:0]  d;
        digit_beat_t                  b;
        int                           k;
        base = 64'(radix_reg);
        if (radix_reg < rdc_pkg::RADIX_MIN)
            base = 64'(rdc_pkg::RADIX_MIN);
        else if (radix_reg > rdc_pkg::RADIX_MAX)
            base = 64'(rdc_pkg::RADIX_MAX);
        quot = 64'(v);
        do
        begin
            rems.push_back(rdc_pkg::DIGIT_W'(quot % base));
            quot = quot / base;
        end
        while (quot != 0 && rems.size() < digit_cap);
        for (k = rems.size() - 1; k >= 0; k--)
        begin
            d = rems[k];
            b.chr  = (d < TEN) ? CH_ZERO + 7'(d) : CH_ALPHA + 7'(d - TEN);
            b.last = (k == 0);
            pending_digits.push_back(b);
        end
    endfunction

    function void report(string what, digit_beat_t exp_b, logic [6:0] chr, logic last);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected char %0d last %0b, got char %0d last %0b",
                     what, exp_b.chr, exp_b.last, chr, last);
    endfunction

    function void check_digit(logic [rdc_pkg::CHAR_W-1:0] chr, logic last);
        digit_beat_t exp_b;
        if (pending_digits.size() == 0)
        begin
            exp_b.chr  = '0;
            exp_b.last = 1'b0;
            report("unexpected digit beat", exp_b, chr, last);
        end
        else
        begin
            exp_b = pending_digits.pop_front();
            if (chr !== exp_b.chr || last !== exp_b.last)
                report("digit mismatch", exp_b, chr, last);
        end
    endfunction
endclass

module tb_radix_digit_converter_core;

    localparam int DIGIT_CAP = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 30;
    localparam logic [rdc_pkg::VALUE_W-1:0] VALUE_MAX = '1;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [rdc_pkg::RADIX_W-1:0]   cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [rdc_pkg::TDATA_IN-1:0]  s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [rdc_pkg::TDATA_OUT-1:0] m_tdata;
    logic                          m_tlast;

    bit steady   = 1'b0;
    bit hold_req = 1'b0;

    digit_scoreboard sb = new(DIGIT_CAP);

    always #5 clk = ~clk;

    radix_digit_converter_core #(
        .MAX_DIGITS (DIGIT_CAP)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    task automatic send_value(input logic [rdc_pkg::VALUE_W-1:0] v);
        if (!steady)
        begin
            while ($urandom_range(99) < 33)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(rdc_pkg::TDATA_IN - rdc_pkg::VALUE_W){1'b0}}, v};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_value(v);
    endtask

    // radix may only change once every digit has drained
    task automatic write_radix(input logic [rdc_pkg::RADIX_W-1:0] r);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_digits.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_radix(r);
    endtask

    function automatic logic [rdc_pkg::VALUE_W-1:0] pick_value();
        logic [rdc_pkg::VALUE_W-1:0] v;
        v = rdc_pkg::VALUE_W'({$urandom, $urandom});
        case ($urandom_range(9))
            0: v = rdc_pkg::VALUE_W'($urandom_range(40));
            1: v = VALUE_MAX;
            2, 3, 4: v = v >> $urandom_range(rdc_pkg::VALUE_W - 1);
            default: ;
        endcase
        return v;
    endfunction

    // output side: random backpressure, plus one long hold-off on request
    initial
    begin : sink
        int unsigned hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_digit(m_tdata[rdc_pkg::CHAR_W-1:0], m_tlast);
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 33);
        end
    end

    initial
    begin : timeout
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : main
        logic [rdc_pkg::RADIX_W-1:0] phase_radix[12];
        int p;
        int i;
        phase_radix = '{5'd0, 5'd2, 5'd10, 5'd16, 5'd31, 5'd1,
                        5'd17, 5'd3, 5'd8, 5'd10, 5'd7, 5'd15};
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset base is ten
        send_value('0);
        send_value(63'd1);
        send_value(63'd9);
        send_value(63'd10);
        send_value(63'd99);
        send_value(63'd1000);
        send_value(VALUE_MAX);
        write_radix(5'd2);
        send_value('0);
        send_value(63'd1);
        send_value(VALUE_MAX);
        send_value(63'h4000_0000_0000_0000);
        write_radix(5'd16);
        send_value('0);
        send_value(63'd15);
        send_value(63'd16);
        send_value(63'h7EDC_BA98_7654_3210);
        send_value(VALUE_MAX);
        // out-of-range register values saturate to 2 and 16
        write_radix(5'd0);
        send_value(63'd5);
        write_radix(5'd1);
        send_value(63'd3);
        write_radix(5'd31);
        send_value(63'd255);
        write_radix(5'd17);
        send_value(63'h0ABC_DEF0);

        for (p = 0; p < 12; p++)
        begin
            write_radix((p == 8) ? rdc_pkg::RADIX_W'($urandom_range(31)) : phase_radix[p]);
            steady = (p == 3);
            if (p == 6)
                hold_req = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++)
                send_value(pick_value());
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_digits.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_digits.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== radix_digit_converter_core.f =====
rtl/rdc_pkg.sv
rtl/rdc_divider.sv
rtl/rdc_digit_ram.sv
rtl/rdc_out_buf.sv
rtl/radix_digit_converter_core.sv
tb/tb_radix_digit_converter_core.sv
